// ===== src/assert_macros.svh =====
// Assertion macros shared by the classifier modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== src/abic_pkg.sv =====
// Types and constants shared by the address bar input classifier.
package abic_pkg;

   localparam logic [2:0] DotSat   = 3'd4;
   localparam logic [2:0] QuadDots = 3'd3;
   localparam logic [8:0] PartMax  = 9'd255;
   localparam logic [8:0] PartSat  = 9'd256;

   localparam logic [7:0] CharDot   = 8'h2E;
   localparam logic [7:0] CharColon = 8'h3A;
   localparam logic [7:0] CharSlash = 8'h2F;
   localparam logic [7:0] CharZero  = 8'h30;
   localparam logic [7:0] CharNine  = 8'h39;
   localparam logic [7:0] CharSpace = 8'h20;
   localparam logic [7:0] CharTab   = 8'h09;
   localparam logic [7:0] CharLf    = 8'h0A;
   localparam logic [7:0] CharCr    = 8'h0D;

   typedef enum logic [1:0] {
      CAT_IPV4   = 2'd0,
      CAT_QUERY  = 2'd1,
      CAT_SCHEME = 2'd2,
      CAT_HOST   = 2'd3
   } category_type;

   typedef enum logic [1:0] {
      SCH_IDLE  = 2'd0,
      SCH_COLON = 2'd1,
      SCH_SLASH = 2'd2
   } scheme_type;

   typedef struct packed {
      logic [7:0] char_code;
      logic       end_of_text;
   } item_type;

   typedef struct packed {
      logic       started;
      logic       pending_space;
      logic [2:0] dot_count;
      logic [8:0] part_value;
      logic       part_nonempty;
      logic       ip_still_ok;
      scheme_type scheme_match_progress;
      logic       has_scheme_mark;
      logic       has_dot;
   } state_type;

   localparam state_type StateReset = '{
      started:               1'b0,
      pending_space:         1'b0,
      dot_count:             3'd0,
      part_value:            9'd0,
      part_nonempty:         1'b0,
      ip_still_ok:           1'b1,
      scheme_match_progress: SCH_IDLE,
      has_scheme_mark:       1'b0,
      has_dot:               1'b0
   };

endpackage

// ===== src/abic_core.sv =====
// Classification state and its per-character update.
`include "assert_macros.svh"

module abic_core
   import abic_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         fire,
   input  item_type     item,
   output category_type category
);

   state_type state_ff;
   state_type state_in;

   // Effect of one counted byte of the trimmed text.
   function automatic state_type take_byte(state_type s, logic [7:0] c);
      state_type  r;
      logic [11:0] v;
      r = s;
      v = 12'({3'b000, s.part_value} * 12'd10) + {8'h00, c[3:0]};
      if (c == CharDot) begin
         if (!s.part_nonempty) r.ip_still_ok = 1'b0;
         if (s.dot_count < DotSat) r.dot_count = s.dot_count + 3'd1;
         if (r.dot_count > QuadDots) r.ip_still_ok = 1'b0;
         r.has_dot       = 1'b1;
         r.part_value    = '0;
         r.part_nonempty = 1'b0;
      end else if (c >= CharZero && c <= CharNine) begin
         r.part_value = (v > {3'b000, PartSat}) ? PartSat : v[8:0];
         if (r.part_value > PartMax) r.ip_still_ok = 1'b0;
         r.part_nonempty = 1'b1;
      end else begin
         r.ip_still_ok   = 1'b0;
         r.part_nonempty = 1'b1;
      end
      if (c == CharColon) begin
         r.scheme_match_progress = SCH_COLON;
      end else if (c == CharSlash && s.scheme_match_progress == SCH_COLON) begin
         r.scheme_match_progress = SCH_SLASH;
      end else if (c == CharSlash && s.scheme_match_progress == SCH_SLASH) begin
         r.has_scheme_mark       = 1'b1;
         r.scheme_match_progress = SCH_IDLE;
      end else begin
         r.scheme_match_progress = SCH_IDLE;
      end
      return r;
   endfunction

   always_comb begin
      if (state_ff.started && state_ff.ip_still_ok && state_ff.dot_count == QuadDots &&
          state_ff.part_nonempty && state_ff.part_value <= PartMax) begin
         category = CAT_IPV4;
      end else if (state_ff.started && !state_ff.has_scheme_mark && !state_ff.has_dot) begin
         category = CAT_QUERY;
      end else if (state_ff.has_scheme_mark) begin
         category = CAT_SCHEME;
      end else begin
         category = CAT_HOST;
      end
   end

   always_comb begin
      state_in = state_ff;
      if (fire) begin
         if (item.end_of_text) begin
            state_in = StateReset;
         end else if (item.char_code inside {CharSpace, CharTab, [CharLf:CharCr]}) begin
            if (state_ff.started) state_in.pending_space = 1'b1;
         end else begin
            if (state_ff.pending_space) state_in = take_byte(state_in, CharSpace);
            state_in.pending_space = 1'b0;
            state_in.started       = 1'b1;
            state_in = take_byte(state_in, item.char_code);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StateReset;
      end else begin
         state_ff <= state_in;
      end
   end

   `ASSERT_SAME(a_pending_needs_start, state_ff.pending_space, state_ff.started)
   `ASSERT_NEXT(a_clear_after_end, fire && item.end_of_text, state_ff == StateReset)
   `ASSERT_SAME(a_counts_saturate, 1'b1, state_ff.dot_count <= DotSat && state_ff.part_value <= PartSat)

endmodule

// ===== src/address_bar_input_classifier.sv =====
// Top level of the address bar input classifier.
// The block takes the text of an address bar one character per beat on the req_ channel,
// closed by a beat with req_end_of_text set, and answers each closing beat with one rsp_
// beat whose category is 0 for a dotted-quad IPv4 address, 1 for a search query, 2 for a
// URL with a scheme and 3 for a bare host; character beats give no result. Leading and
// trailing whitespace is ignored, and after the closing beat the block is ready for the
// next text at once. One beat is accepted every clock cycle unless the input is held back:
// a beat sits in the input register while the character update and the classification run
// on it, and the category is loaded into the result register as the closing beat leaves the
// input register, from where the result is offered. The only thing that holds the input back
// is a closing beat that finds the result register still full and stalled.
`include "assert_macros.svh"

module address_bar_input_classifier
   import abic_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_char_code,
   input  logic       req_end_of_text,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_category
);

   // Input register.
   logic         s1_valid_ff;
   logic         s1_valid_in;
   item_type     s1_item_ff;
   logic         s1_move;
   logic         req_accept;

   // Result register.
   logic         rsp_valid_ff;
   logic         rsp_valid_in;
   category_type rsp_category_ff;
   category_type category;
   logic         emit;

   // A character beat always moves on; a closing beat waits only while the result
   // register holds a result that the far side is not yet taking.
   assign s1_move    = s1_valid_ff && !(s1_item_ff.end_of_text && rsp_valid_ff && rsp_stall);
   assign req_stall  = s1_valid_ff && !s1_move;
   assign req_accept = req_valid && !req_stall;
   assign emit       = s1_move && s1_item_ff.end_of_text;

   always_comb begin
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_comb begin
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_item_ff.char_code   <= req_char_code;
         s1_item_ff.end_of_text <= req_end_of_text;
      end
      if (emit) begin
         rsp_category_ff <= category;
      end
   end

   abic_core u_core (
      .clock    (clock),
      .reset    (reset),
      .fire     (s1_move),
      .item     (s1_item_ff),
      .category (category)
   );

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_category = rsp_category_ff;

   `ASSERT_NEXT(a_end_gives_result, emit, rsp_valid_ff)
   `ASSERT_NEXT(a_no_extra_result, !emit && !(rsp_valid_ff && rsp_stall), !rsp_valid_ff)
   `ASSERT_SAME(a_stall_cause, req_stall, s1_valid_ff && s1_item_ff.end_of_text && rsp_valid_ff)

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for the address bar input classifier.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import abic_pkg::*;

   // Vertical tab and form feed are whitespace too, but the package has no name for them.
   localparam logic [7:0] CharVt = 8'h0B;
   localparam logic [7:0] CharFf = 8'h0C;

   // Longest stretch without any beat on either channel before the run is abandoned.
   // The receiver's deliberate hold-off, HoldOffCycles, is far shorter, so this leaves a wide margin.
   localparam int StallLimit = 5000;
   localparam int HoldOffCycles = 300;

   // Tracks the text being typed, beat by beat, and keeps the categories still owed by
   // the block in the order in which their closing beats were accepted.
   class category_tracker;
      state_type    text_st;
      category_type categories_due[$];
      int           mismatches;

      function new();
         clear_text();
         mismatches = 0;
      endfunction

      function void clear_text();
         text_st = StateReset;
      endfunction

      function bit is_blank(logic [7:0] c);
         return c == CharSpace || c == CharTab || c == CharLf || c == CharVt ||
                c == CharFf || c == CharCr;
      endfunction

      // One character of the trimmed text.
      function void consume_char(logic [7:0] c);
         int grown;
         if (c == CharDot) begin
            if (!text_st.part_nonempty) text_st.ip_still_ok = 1'b0;
            if (text_st.dot_count < DotSat) text_st.dot_count = text_st.dot_count + 3'd1;
            if (text_st.dot_count > QuadDots) text_st.ip_still_ok = 1'b0;
            text_st.has_dot       = 1'b1;
            text_st.part_value    = '0;
            text_st.part_nonempty = 1'b0;
         end else if (c >= CharZero && c <= CharNine) begin
            grown = int'(text_st.part_value) * 10 + int'(c - CharZero);
            text_st.part_value = (grown > int'(PartSat)) ? PartSat : 9'(grown);
            if (text_st.part_value > PartMax) text_st.ip_still_ok = 1'b0;
            text_st.part_nonempty = 1'b1;
         end else begin
            text_st.ip_still_ok   = 1'b0;
            text_st.part_nonempty = 1'b1;
         end

         if (c == CharColon) begin
            text_st.scheme_match_progress = SCH_COLON;
         end else if (c == CharSlash && text_st.scheme_match_progress == SCH_COLON) begin
            text_st.scheme_match_progress = SCH_SLASH;
         end else if (c == CharSlash && text_st.scheme_match_progress == SCH_SLASH) begin
            text_st.has_scheme_mark       = 1'b1;
            text_st.scheme_match_progress = SCH_IDLE;
         end else begin
            text_st.scheme_match_progress = SCH_IDLE;
         end
      endfunction

      function category_type classify();
         if (text_st.started && text_st.ip_still_ok && text_st.dot_count == QuadDots &&
             text_st.part_nonempty && text_st.part_value <= PartMax) begin
            return CAT_IPV4;
         end else if (text_st.started && !text_st.has_scheme_mark && !text_st.has_dot) begin
            return CAT_QUERY;
         end else if (text_st.has_scheme_mark) begin
            return CAT_SCHEME;
         end
         return CAT_HOST;
      endfunction

      // Called for every accepted input beat.
      function void absorb_beat(logic [7:0] c, logic last);
         if (last) begin
            categories_due.push_back(classify());
            clear_text();
            return;
         end
         if (is_blank(c)) begin
            if (text_st.started) text_st.pending_space = 1'b1;
            return;
         end
         // A run of inner whitespace counts once, as a single space.
         if (text_st.pending_space) begin
            consume_char(CharSpace);
            text_st.pending_space = 1'b0;
         end
         text_st.started = 1'b1;
         consume_char(c);
      endfunction

      // Called for every accepted result beat.
      function void compare_category(logic [1:0] got);
         category_type want;
         if (categories_due.size() == 0) begin
            $error("category: no result expected, actual %0d", got);
            mismatches++;
            return;
         end
         want = categories_due.pop_front();
         if (got !== want) begin
            $error("category: expected %0d, actual %0d", want, got);
            mismatches++;
         end
      endfunction

      function int pending();
         return categories_due.size();
      endfunction
   endclass

   // All inputs start at a known value; reset is high from time zero.
   logic       clock           = 1'b0;
   logic       reset           = 1'b1;
   logic       req_valid       = 1'b0;
   logic       req_stall;
   logic [7:0] req_char_code   = 8'h00;
   logic       req_end_of_text = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall       = 1'b0;
   logic [1:0] rsp_category;

   category_tracker tracker = new();

   bit         calm         = 1'b0;  // while set, neither side idles
   int         holdoff_req  = 0;     // bumped by the stimulus to ask for a long receiver stall
   int         beats_sent   = 0;
   int         quiet_cycles = 0;
   logic [7:0] text_bytes[$];        // the text currently being assembled

   address_bar_input_classifier dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_char_code   (req_char_code),
      .req_end_of_text (req_end_of_text),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_category    (rsp_category)
   );

   always #1 clock = ~clock;

   // Each side idles in roughly a third of its cycles, except during the calm stretch.
   function automatic bit idle_now();
      return !calm && $urandom_range(99) < 34;
   endfunction

   // ---------------------------------------------------------------------------------
   // Text generation. Each helper appends characters to text_bytes; a whole text is
   // then sent as one beat per character followed by the closing beat.
   // ---------------------------------------------------------------------------------

   function automatic void put_str(string s);
      for (int i = 0; i < s.len(); i++) text_bytes.push_back(s[i]);
   endfunction

   function automatic void put_ws();
      case ($urandom_range(0, 5))
         0: text_bytes.push_back(CharSpace);
         1: text_bytes.push_back(CharTab);
         2: text_bytes.push_back(CharLf);
         3: text_bytes.push_back(CharVt);
         4: text_bytes.push_back(CharFf);
         default: text_bytes.push_back(CharCr);
      endcase
   endfunction

   // Leading or trailing padding, often none at all.
   function automatic void put_pad();
      repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0) put_ws();
   endfunction

   // Mostly valid octets, but also values just past the limit and very long digit runs,
   // which must saturate rather than wrap.
   function automatic void put_number();
      int v;
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 6) v = $urandom_range(0, 255);
      else if (pick < 8) v = $urandom_range(256, 999);
      else if (pick == 8) v = $urandom_range(255, 256);
      else v = $urandom_range(0, 99999999);
      if ($urandom_range(0, 7) == 0) text_bytes.push_back(CharZero);
      put_str($sformatf("%0d", v));
   endfunction

   // A word of letters, digits, hyphens and the odd byte from the upper half of the code.
   function automatic void put_word();
      repeat ($urandom_range(1, 6)) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: text_bytes.push_back(8'("a") + 8'($urandom_range(0, 25)));
            6, 7: text_bytes.push_back(CharZero + 8'($urandom_range(0, 9)));
            8: text_bytes.push_back(8'("-"));
            default: text_bytes.push_back(8'($urandom_range(128, 255)));
         endcase
      end
   endfunction

   function automatic void put_dotted_words(int parts);
      for (int i = 0; i < parts; i++) begin
         if (i > 0) text_bytes.push_back(CharDot);
         put_word();
      end
   endfunction

   // Most texts are well formed in shape (a dotted quad, a URL, a query, a host name) with
   // random content, so the deeper states of the classifier get exercised; the rest is
   // noise, partly drawn from the characters that the classifier cares about.
   function automatic void build_random_text();
      int parts;
      text_bytes.delete();
      put_pad();
      case ($urandom_range(0, 9))
         0, 1, 2: begin
            parts = ($urandom_range(0, 4) != 0) ? 4 : $urandom_range(1, 6);
            for (int i = 0; i < parts; i++) begin
               if (i > 0) text_bytes.push_back(CharDot);
               case ($urandom_range(0, 19))
                  0: ;
                  1: put_word();
                  2: begin
                     put_number();
                     put_ws();
                  end
                  default: put_number();
               endcase
            end
         end
         3, 4: begin
            put_word();
            case ($urandom_range(0, 5))
               4: put_str(":/");
               5: begin
                  text_bytes.push_back(CharColon);
                  put_word();
                  put_str("//");
               end
               default: put_str("://");
            endcase
            put_dotted_words($urandom_range(1, 3));
            if ($urandom_range(0, 1)) begin
               text_bytes.push_back(CharSlash);
               put_word();
            end
         end
         5: begin
            put_word();
            repeat ($urandom_range(0, 3)) begin
               repeat ($urandom_range(1, 3)) put_ws();
               put_word();
            end
         end
         6: begin
            put_dotted_words($urandom_range(2, 3));
            if ($urandom_range(0, 2) == 0) begin
               text_bytes.push_back(CharColon);
               put_number();
            end
         end
         7: repeat ($urandom_range(0, 10)) text_bytes.push_back(8'($urandom_range(1, 255)));
         8: begin
            repeat ($urandom_range(1, 12)) begin
               case ($urandom_range(0, 5))
                  0: text_bytes.push_back(CharDot);
                  1: text_bytes.push_back(CharColon);
                  2: text_bytes.push_back(CharSlash);
                  3: put_ws();
                  4: text_bytes.push_back(8'("x"));
                  default: text_bytes.push_back(CharZero + 8'($urandom_range(0, 9)));
               endcase
            end
         end
         default: ;  // empty, or whitespace only once padded
      endcase
      put_pad();
   endfunction

   // ---------------------------------------------------------------------------------
   // Driving. Inputs change only by nonblocking assignment just after a rising edge;
   // handshake signals are read straight after the edge, which gives the values that
   // the block itself saw at that edge.
   // ---------------------------------------------------------------------------------

   task automatic offer_beat(input logic [7:0] code, input logic last);
      while (idle_now()) begin
         req_valid       <= 1'b0;
         req_char_code   <= 8'($urandom);
         req_end_of_text <= 1'($urandom);
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_char_code   <= code;
      req_end_of_text <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tracker.absorb_beat(code, last);
      beats_sent++;
   endtask

   // The character code of the closing beat is random, since the block must ignore it.
   task automatic send_text();
      foreach (text_bytes[i]) offer_beat(text_bytes[i], 1'b0);
      offer_beat(8'($urandom), 1'b1);
   endtask

   task automatic send_random_text();
      build_random_text();
      send_text();
   endtask

   // The sender stops offering until every category owed has come back.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.pending() != 0) @(posedge clock);
   endtask

   // Receiver: checks each accepted result beat and drives its stall. When the stimulus
   // asks for it, it holds the block off for a long stretch, counted here, so that the
   // result register fills and the block has to stall its input.
   initial begin : receiver
      int hold_left;
      int seen_req;
      hold_left = 0;
      seen_req  = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) tracker.compare_category(rsp_category);
         if (holdoff_req != seen_req) begin
            seen_req  = holdoff_req;
            hold_left = HoldOffCycles;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= idle_now();
         end
      end
   end

   // Count cycles in which neither channel moves a beat.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : watchdog
      while (quiet_cycles < StallLimit) @(posedge clock);
      $display("Regression FAIL");
      $finish;
   end

   initial begin : stimulus
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed texts. An end marker with nothing before it is the empty text.
      text_bytes.delete();
      send_text();

      // A dotted quad with both octet extremes, a leading zero, and whitespace at both
      // ends that must be trimmed away.
      text_bytes = {CharSpace, CharTab};
      put_str("0.01.2.255");
      text_bytes.push_back(CharCr);
      send_text();

      // A one-letter word followed by a scheme mark.
      text_bytes.delete();
      put_str("a://");
      send_text();

      // An overlong digit run, then a mixed run of inner whitespace: still a query.
      text_bytes.delete();
      put_str("99999");
      text_bytes.push_back(CharVt);
      text_bytes.push_back(CharFf);
      text_bytes.push_back(CharLf);
      put_str("q");
      send_text();

      // The top byte and the zero byte, both ordinary non-space characters.
      text_bytes = {8'hFF, 8'h00};
      send_text();

      // Random texts with both sides idling at random.
      while (beats_sent < 300) send_random_text();
      drain();

      // A long stretch in which neither side idles, so the block runs at full rate.
      calm = 1'b1;
      while (beats_sent < 450) send_random_text();
      calm = 1'b0;

      // The receiver holds off while the sender keeps going; the block must fill up and
      // push back on its input rather than lose or reorder a category.
      holdoff_req++;
      repeat (8) send_random_text();
      drain();

      while (beats_sent < 900) send_random_text();

      drain();
      repeat (8) @(posedge clock);
      if (tracker.mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
